[rtl/core/oss_pkg.sv]
package oss_pkg;

    // Fixed field widths.
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] REQ_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] REQ_LOOKUP = 3'd2;
    localparam logic [KIND_W-1:0] REQ_READ   = 3'd3;
    localparam logic [KIND_W-1:0] REQ_MARK   = 3'd4;
    localparam logic [KIND_W-1:0] REQ_SWEEP  = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

    // One request item.
    typedef struct packed {
        logic [KIND_W-1:0]         req_type;
        logic signed [VALUE_W-1:0] item_value;
        logic [INDEX_W-1:0]        item_index;
    } req_item_t;

    // One result item.
    typedef struct packed {
        logic                      found;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        entry_count;
        logic [STAT_W-1:0]         status;
    } rsp_item_t;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic capture;
        logic sweep;
        logic shift;
        logic insert;
        logic set_mark;
        logic clear_marks;
    } cell_ctl_t;

    // Status reported by one cell.
    typedef struct packed {
        logic                      occupied;
        logic                      hit;
        logic                      sel;
        logic                      mark;
        logic signed [VALUE_W-1:0] cell_value;
    } cell_stat_t;

endpackage

[rtl/core/ordered_unique_set_store.sv]
// Channel  Direction  Handshake          Payload
// req      in         req_valid/req_stall req_item_t: req_type, item_value, item_index
// rsp      out        rsp_valid/rsp_stall rsp_item_t: found, read_value, entry_count, status
//
// Every cell compares its entry against the request value at the accept edge, so
// insert, remove, lookup, read and mark are accepted, then applied in an update step.
// A sweep drops unmarked entries one at a time: the chain drops one entry per cycle
// by shifting its right-hand neighbors down.
// Reset clears the fill count and all keep marks at once; there is no clearing pass.
// A held result waits in the output register; a new item is still accepted then,
// and its update waits until the output register is free.
module ordered_unique_set_store
    import oss_pkg::*;
#(
    parameter int SET_DEPTH = 64
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int CW = $clog2(SET_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_APPLY = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    req_item_t      req_reg;
    rsp_item_t      rsp_reg, rsp_next;
    logic           rsp_valid_reg;

    cell_ctl_t      ctl;
    cell_stat_t     stat [SET_DEPTH];
    logic [SET_DEPTH:0]   kill_chain;
    logic [SET_DEPTH-1:0] hit_vec;
    logic [SET_DEPTH-1:0] sel_vec;
    logic [SET_DEPTH-1:0] mark_vec;
    logic [SET_DEPTH-1:0] occ_vec;

    logic signed [VALUE_W-1:0] read_data;
    logic req_accept;
    logic out_free;
    logic apply_go;
    logic sweep_done;
    logic any_hit;
    logic any_kill;
    logic in_range;
    logic full;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign apply_go   = (state_reg == S_APPLY) && out_free;
    assign sweep_done = (state_reg == S_SWEEP) && !any_kill && out_free;
    assign full       = (count_reg == CW'(SET_DEPTH));

    // Chain of cells; drop requests ripple from left to right.
    assign kill_chain[0] = 1'b0;

    for (genvar i = 0; i < SET_DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] nb_value;
        logic                      nb_mark;

        if (i == SET_DEPTH - 1)
        begin : g_last
            assign nb_value = '0;
            assign nb_mark  = 1'b0;
        end
        else
        begin : g_mid
            assign nb_value = stat[i+1].cell_value;
            assign nb_mark  = stat[i+1].mark;
        end

        oss_cell #(
            .SET_DEPTH  (SET_DEPTH),
            .CELL_INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .cmp_value (req.item_value),
            .wr_value  (req_reg.item_value),
            .cmp_index (req.item_index),
            .count     (count_reg),
            .nb_value  (nb_value),
            .nb_mark   (nb_mark),
            .kill_in   (kill_chain[i]),
            .kill_out  (kill_chain[i+1]),
            .stat      (stat[i])
        );

        assign hit_vec[i]  = stat[i].hit;
        assign sel_vec[i]  = stat[i].sel;
        assign mark_vec[i] = stat[i].mark;
        assign occ_vec[i]  = stat[i].occupied;
    end

    assign any_hit  = |hit_vec;
    assign any_kill = kill_chain[SET_DEPTH];
    assign in_range = |sel_vec;

    // Read data: at most one occupied cell is selected by the index.
    always_comb
    begin
        read_data = '0;
        for (int i = 0; i < SET_DEPTH; i++)
        begin
            read_data = read_data | (stat[i].cell_value & {VALUE_W{stat[i].sel}});
        end
    end

    // Broadcast controls.
    always_comb
    begin
        ctl.capture     = req_accept;
        ctl.sweep       = (state_reg == S_SWEEP);
        ctl.shift       = (apply_go && req_reg.req_type == REQ_REMOVE && any_hit)
                          || ((state_reg == S_SWEEP) && any_kill);
        ctl.insert      = apply_go && req_reg.req_type == REQ_INSERT && !any_hit && !full;
        ctl.set_mark    = apply_go && req_reg.req_type == REQ_MARK;
        ctl.clear_marks = sweep_done;
    end

    // Fill count update.
    always_comb
    begin
        count_next = count_reg;
        if (ctl.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.shift)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Result for the item being finished.
    always_comb
    begin
        rsp_next             = '0;
        rsp_next.entry_count = COUNT_W'(count_next);
        rsp_next.status      = STATUS_OK;
        if (state_reg == S_APPLY)
        begin
            unique case (req_reg.req_type) inside
                REQ_INSERT:
                begin
                    rsp_next.found = any_hit;
                    if (!any_hit && full)
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                end
                REQ_REMOVE, REQ_LOOKUP, REQ_MARK:
                begin
                    rsp_next.found = any_hit;
                end
                REQ_READ:
                begin
                    if (in_range)
                    begin
                        rsp_next.read_value = read_data;
                    end
                    else
                    begin
                        rsp_next.status = STATUS_RANGE;
                    end
                end
                default:
                begin
                    rsp_next.found = 1'b0;
                end
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = (req.req_type == REQ_SWEEP) ? S_SWEEP : S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (apply_go || sweep_done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_reg <= req;
        end
        if (apply_go || sweep_done)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // The fill count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SET_DEPTH))
        else $error("fill count beyond depth");

    // Entries are distinct, so at most one occupied cell matches.
    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(hit_vec))
        else $error("more than one matching entry");

    // Cells past the fill count never carry a keep mark.
    a_marks_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (mark_vec & ~occ_vec) == '0)
        else $error("keep mark outside held entries");

    // A finished sweep leaves every mark cleared.
    a_sweep_clears: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_done |=> (mark_vec == '0))
        else $error("marks left after sweep");

    // A new result only appears when an item is being finished.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("result without an item in work");
`endif

endmodule

[rtl/core/oss_cell.sv]
module oss_cell
    import oss_pkg::*;
#(
    parameter int SET_DEPTH  = 64,
    parameter int CELL_INDEX = 0
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cell_ctl_t                         ctl,
    input  logic signed [VALUE_W-1:0]         cmp_value,
    input  logic signed [VALUE_W-1:0]         wr_value,
    input  logic [INDEX_W-1:0]                cmp_index,
    input  logic [$clog2(SET_DEPTH+1)-1:0]    count,
    input  logic signed [VALUE_W-1:0]         nb_value,
    input  logic                              nb_mark,
    input  logic                              kill_in,
    output logic                              kill_out,
    output cell_stat_t                        stat
);

    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam logic [CW-1:0] MY_POS = CW'(CELL_INDEX);
    localparam bit IDX_OK = (CELL_INDEX < (1 << INDEX_W));
    localparam logic [INDEX_W-1:0] IDX_CODE = INDEX_W'(CELL_INDEX);

    logic signed [VALUE_W-1:0] value_reg;
    logic                      mark_reg;
    logic                      hit_reg;
    logic                      sel_reg;
    logic                      occ;
    logic                      kill;
    logic                      shift_en;
    logic                      ins_here;
    logic                      idx_match;

    // The cell holds an entry when its position is below the fill count.
    assign occ       = MY_POS < count;
    assign idx_match = IDX_OK && (cmp_index == IDX_CODE);
    assign ins_here  = ctl.insert && (count == MY_POS);

    // A cell is dropped on a matching remove or, in a sweep, when unmarked.
    assign kill     = occ & (ctl.sweep ? ~mark_reg : hit_reg);
    assign kill_out = kill_in | kill;
    assign shift_en = ctl.shift & kill_out;

    // Compare and index match are taken when the item is accepted.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            hit_reg <= (value_reg == cmp_value);
            sel_reg <= idx_match;
        end
    end

    // Entry value: shifts in from the right neighbor or takes a new insert.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= nb_value;
        end
        else if (ins_here)
        begin
            value_reg <= wr_value;
        end
    end

    // Keep mark travels with its entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else if (ctl.clear_marks)
        begin
            mark_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            mark_reg <= nb_mark;
        end
        else if (ins_here)
        begin
            mark_reg <= 1'b0;
        end
        else if (ctl.set_mark && hit_reg && occ)
        begin
            mark_reg <= 1'b1;
        end
    end

    assign stat.occupied   = occ;
    assign stat.hit        = hit_reg & occ;
    assign stat.sel        = sel_reg & occ;
    assign stat.mark       = mark_reg;
    assign stat.cell_value = value_reg;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import oss_pkg::*;

    localparam int SET_DEPTH       = 64;
    localparam int POOL_SIZE       = 96;
    localparam int RANDOM_ITEMS    = 350;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 200;
    localparam int TIMEOUT_NS      = 1_000_000;

    // Request kinds the block has no meaning for.
    localparam logic [KIND_W-1:0] REQ_RESERVED_A = 3'd6;
    localparam logic [KIND_W-1:0] REQ_RESERVED_B = 3'd7;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    // Expected state of the set, updated as each item is accepted.
    logic signed [VALUE_W-1:0] set_values [SET_DEPTH];
    logic                      set_marks [SET_DEPTH];
    int                        held_entries = 0;

    rsp_item_t expected_results [$];
    logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int dropped_inserts = 0;
    int range_reads = 0;
    int sweeps_done = 0;

    // Sender and receiver idling controls.
    bit sender_gaps = 1'b0;
    int burst_left = 0;
    bit stall_enable = 1'b0;
    bit hold_off_pending = 1'b0;
    int hold_left = 0;
    logic [15:0] stall_pattern = '0;
    int pattern_left = 0;

    ordered_unique_set_store #(
        .SET_DEPTH(SET_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Computes the result of one request and applies it to the expected set.
    function automatic rsp_item_t apply_set_request(req_item_t r);
        rsp_item_t res;
        int pos;
        int keep;
        int i;
        res = '0;
        pos = held_entries;
        for (i = held_entries - 1; i >= 0; i--)
        begin
            if (set_values[i] == r.item_value)
                pos = i;
        end
        case (r.req_type)
            REQ_INSERT:
            begin
                if (pos < held_entries)
                    res.found = 1'b1;
                else if (held_entries >= SET_DEPTH)
                begin
                    res.status = STATUS_FULL;
                    dropped_inserts++;
                end
                else
                begin
                    set_values[held_entries] = r.item_value;
                    set_marks[held_entries] = 1'b0;
                    held_entries++;
                end
            end
            REQ_REMOVE:
            begin
                if (pos < held_entries)
                begin
                    res.found = 1'b1;
                    // Close the gap; marks travel with their entries.
                    for (i = pos; i < held_entries - 1; i++)
                    begin
                        set_values[i] = set_values[i + 1];
                        set_marks[i] = set_marks[i + 1];
                    end
                    held_entries--;
                    set_marks[held_entries] = 1'b0;
                end
            end
            REQ_LOOKUP:
                res.found = (pos < held_entries);
            REQ_READ:
            begin
                if (r.item_index < held_entries)
                    res.read_value = set_values[r.item_index];
                else
                begin
                    res.status = STATUS_RANGE;
                    range_reads++;
                end
            end
            REQ_MARK:
            begin
                if (pos < held_entries)
                begin
                    res.found = 1'b1;
                    set_marks[pos] = 1'b1;
                end
            end
            REQ_SWEEP:
            begin
                // Keep marked entries in order and clear every mark.
                keep = 0;
                for (i = 0; i < held_entries; i++)
                begin
                    if (set_marks[i])
                    begin
                        set_values[keep] = set_values[i];
                        keep++;
                    end
                end
                held_entries = keep;
                for (i = 0; i < SET_DEPTH; i++)
                    set_marks[i] = 1'b0;
                sweeps_done++;
            end
            default:
            begin
            end
        endcase
        res.entry_count = COUNT_W'(held_entries);
        return res;
    endfunction

    // Offers one item, waits for it to be taken, then maybe pauses.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic signed [VALUE_W-1:0] value,
                                input logic [INDEX_W-1:0] index);
        req_item_t item;
        item.req_type = kind;
        item.item_value = value;
        item.item_index = index;
        req <= item;
        req_valid <= 1'b1;
        do
            @(negedge clk);
        while (req_stall);
        @(posedge clk);
        expected_results.push_back(apply_set_request(item));
        items_sent++;
        if (sender_gaps && burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 10);
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    // Mostly values held now, some from the pool, a few anywhere.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (held_entries > 0 && roll < 55)
            return set_values[$urandom_range(0, held_entries - 1)];
        else if (roll < 90)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if (held_entries > 0 && $urandom_range(0, 99) < 75)
            return INDEX_W'($urandom_range(0, held_entries - 1));
        return INDEX_W'($urandom_range(0, SET_DEPTH - 1));
    endfunction

    // Receiver: a long hold-off on request, otherwise, when enabled, a rotating stall pattern.
    always @(posedge clk)
    begin
        if (hold_off_pending)
        begin
            hold_off_pending = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (!stall_enable)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pattern = '0;
                    1: stall_pattern = 16'($urandom);
                    default: stall_pattern = 16'($urandom & $urandom);
                endcase
                pattern_left = 16;
            end
            rsp_stall <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_left--;
        end
    end

    // Each result taken at the next rising edge is checked against the oldest expectation.
    always @(negedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: %p", rsp);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (rsp.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, rsp.found);
                    error_count++;
                end
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, rsp.read_value);
                    error_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, rsp.entry_count);
                    error_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    error_count++;
                end
            end
        end
    end

    // Every request kind, extreme values and indexes, and the corner cases of marking.
    task automatic test_basic_requests();
        sender_gaps = 1'b1;
        stall_enable = 1'b1;
        send_request(REQ_INSERT, VALUE_MIN, '0);
        send_request(REQ_INSERT, VALUE_MAX, '1);
        send_request(REQ_INSERT, 32'sd0, '0);
        send_request(REQ_INSERT, -32'sd1, '0);
        // A value already held is not added again.
        send_request(REQ_INSERT, VALUE_MAX, '0);
        send_request(REQ_LOOKUP, VALUE_MIN, '0);
        send_request(REQ_LOOKUP, 32'sd1, '0);
        send_request(REQ_READ, 32'sd0, 6'd0);
        send_request(REQ_READ, VALUE_MAX, 6'd3);
        send_request(REQ_READ, 32'sd0, 6'd4);
        send_request(REQ_READ, VALUE_MIN, '1);
        send_request(REQ_MARK, 32'sd7, '0);
        send_request(REQ_MARK, VALUE_MIN, '0);
        send_request(REQ_MARK, -32'sd1, '0);
        // Removing a marked entry takes its mark along; the later mark shifts down.
        send_request(REQ_REMOVE, VALUE_MIN, '0);
        send_request(REQ_REMOVE, 32'sd12345, '0);
        // A fresh entry starts unmarked, so the sweep drops it.
        send_request(REQ_INSERT, 32'sh5555_5555, '0);
        send_request(REQ_SWEEP, 32'sd0, '0);
        send_request(REQ_READ, 32'sd0, 6'd0);
        send_request(REQ_RESERVED_A, -32'sd1, '1);
        send_request(REQ_RESERVED_B, VALUE_MAX, '0);
        send_request(REQ_LOOKUP, VALUE_MAX, '0);
        send_request(REQ_INSERT, 32'sh2AAA_AAAA, '0);
    endtask

    // Start a long receiver hold-off, fill the store completely, then probe it when full.
    task automatic test_full_store();
        logic signed [VALUE_W-1:0] fill_values [SET_DEPTH];
        int i;
        sender_gaps = 1'b0;
        hold_off_pending = 1'b1;
        // A sweep with nothing marked empties the store.
        send_request(REQ_SWEEP, 32'sd0, '0);
        for (i = 0; i < SET_DEPTH; i++)
        begin
            fill_values[i] = {6'(i), 26'($urandom)};
            send_request(REQ_INSERT, fill_values[i], '0);
        end
        send_request(REQ_INSERT, $urandom | 32'sd1, '0);
        send_request(REQ_INSERT, 32'sd0, '0);
        send_request(REQ_INSERT, fill_values[SET_DEPTH - 1], '0);
        send_request(REQ_READ, 32'sd0, '1);
        send_request(REQ_READ, 32'sd0, 6'd0);
        send_request(REQ_MARK, fill_values[SET_DEPTH - 1], '0);
        send_request(REQ_MARK, fill_values[10], '0);
        send_request(REQ_MARK, fill_values[0], '0);
        send_request(REQ_REMOVE, fill_values[10], '0);
        send_request(REQ_READ, 32'sd0, 6'd62);
        send_request(REQ_READ, 32'sd0, '1);
        send_request(REQ_SWEEP, 32'sd0, '0);
        send_request(REQ_READ, 32'sd0, 6'd1);
        send_request(REQ_READ, 32'sd0, 6'd2);
    endtask

    // Random set operations built from well-formed sequences, with some noise.
    task automatic test_random_set_operations();
        int first_item;
        int i;
        first_item = items_sent;
        for (i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        stall_enable = 1'b1;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            sender_gaps = ($urandom_range(0, 9) < 7);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // Union: add a run of values.
                    repeat ($urandom_range(3, 12))
                        send_request(REQ_INSERT, pick_value(), pick_index());
                end
                3, 4:
                begin
                    // Intersection: mark members of a second set, then sweep.
                    repeat ($urandom_range(1, 10))
                        send_request(REQ_MARK, pick_value(), pick_index());
                    if ($urandom_range(0, 3) == 0)
                        send_request(REQ_REMOVE, pick_value(), pick_index());
                    send_request(REQ_SWEEP, $urandom, INDEX_W'($urandom));
                end
                5:
                begin
                    // Difference: remove a run of values.
                    repeat ($urandom_range(2, 6))
                        send_request(REQ_REMOVE, pick_value(), pick_index());
                end
                6, 7:
                begin
                    repeat ($urandom_range(3, 8))
                    begin
                        if ($urandom_range(0, 1) == 0)
                            send_request(REQ_LOOKUP, pick_value(), INDEX_W'($urandom));
                        else
                            send_request(REQ_READ, $urandom, pick_index());
                    end
                end
                default:
                begin
                    // Noise: any kind with any value and index.
                    repeat ($urandom_range(1, 4))
                        send_request(KIND_W'($urandom_range(REQ_INSERT, REQ_RESERVED_B)),
                                     $urandom, INDEX_W'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_requests();
        test_full_store();
        test_random_set_operations();

        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d results, including %0d sweeps.",
                 items_sent, results_checked, sweeps_done);
        $display("Full-store inserts dropped: %0d; reads out of range: %0d.",
                 dropped_inserts, range_reads);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[ordered_unique_set_store.f]
rtl/core/oss_pkg.sv
rtl/core/oss_cell.sv
rtl/core/ordered_unique_set_store.sv
tb/sv/testbench.sv
